// ===== rtl/smsl_pkg.sv =====
// ----------------------------------------------------------------------------
// smsl_pkg
// Shared types, widths and codes of the sorted multiset list unit.
// ----------------------------------------------------------------------------
package smsl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = 5;
    localparam int STATUS_W = 2;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    // commands broadcast to every cell
    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_ROTATE = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [1:0] op;
        t_value     operand;
        logic       found;
    } t_cell_cmd;

endpackage

// ===== rtl/smsl_if.sv =====
// ----------------------------------------------------------------------------
// smsl_req_if / smsl_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface smsl_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [smsl_pkg::KIND_W-1:0]           kind;
    logic signed [smsl_pkg::VALUE_W-1:0]   operand_value;

    modport source (output valid, output kind, output operand_value, input ready);
    modport sink   (input valid, input kind, input operand_value, output ready);
endinterface

interface smsl_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [smsl_pkg::ENTRY_W-1:0]          entry_count;
    logic signed [smsl_pkg::VALUE_W-1:0]   reported_value;
    logic                                  value_present;
    logic                                  last_of_run;
    logic [smsl_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output entry_count, output reported_value,
                    output value_present, output last_of_run, output status,
                    input ready);
    modport sink   (input valid, input entry_count, input reported_value,
                    input value_present, input last_of_run, input status,
                    output ready);
endinterface

// ===== rtl/sorted_multiset_list_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_multiset_list_unit
// Bounded ascending multiset kept in a chain of cells; insert, delete and
// distinct-value report.
// ----------------------------------------------------------------------------
// channel  | dir | words
// i_req    | in  | kind, operand_value
// o_res    | out | entry_count, reported_value, value_present, last_of_run, status
//
// insert, delete and no-op act on the whole chain; every cell compares and shifts at once
// a report rotates the chain once around, one cell per cycle while results are taken:
// one word per distinct value, the head cell and its neighbor deciding each one
// a single output register holds the result; the scan stalls while it is not taken
// requests are refused during a report scan
// synchronous active-low reset empties the list; cell contents are not cleared
// ----------------------------------------------------------------------------
module sorted_multiset_list_unit #(
    parameter int CAPACITY = smsl_pkg::CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    smsl_req_if.sink   i_req,
    smsl_res_if.source o_res
);
    import smsl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;

    logic              r_out_valid, n_out_valid;
    logic [ENTRY_W-1:0] r_out_count, n_out_count;
    t_value            r_out_value, n_out_value;
    logic              r_out_present, n_out_present;
    logic              r_out_last, n_out_last;
    logic [STATUS_W-1:0] r_out_status, n_out_status;

    t_cell_cmd         w_cmd;
    t_value            w_val   [CAPACITY];
    logic              w_ins   [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_used;
    logic              w_slot_free;
    logic              w_accept;
    logic              w_scan_last;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_used[gi] = (CW'(gi) < r_count);
            if (gi == 0) begin : g_head
                smsl_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_used       (w_used[gi]),
                    .i_left_val   (w_val[0]),
                    .i_left_ins   (1'b0),
                    .i_right_val  (w_val[gi+1]),
                    .i_right_used (w_used[gi+1]),
                    .i_head_val   (w_val[0]),
                    .o_val        (w_val[gi]),
                    .o_ins        (w_ins[gi]),
                    .o_match      (w_match[gi])
                );
            end else if (gi == CAPACITY - 1) begin : g_tail
                smsl_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_used       (w_used[gi]),
                    .i_left_val   (w_val[gi-1]),
                    .i_left_ins   (w_ins[gi-1]),
                    .i_right_val  (w_val[0]),
                    .i_right_used (1'b0),
                    .i_head_val   (w_val[0]),
                    .o_val        (w_val[gi]),
                    .o_ins        (w_ins[gi]),
                    .o_match      (w_match[gi])
                );
            end else begin : g_mid
                smsl_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_used       (w_used[gi]),
                    .i_left_val   (w_val[gi-1]),
                    .i_left_ins   (w_ins[gi-1]),
                    .i_right_val  (w_val[gi+1]),
                    .i_right_used (w_used[gi+1]),
                    .i_head_val   (w_val[0]),
                    .o_val        (w_val[gi]),
                    .o_ins        (w_ins[gi]),
                    .o_match      (w_match[gi])
                );
            end
        end
    endgenerate

    assign w_slot_free  = !r_out_valid || o_res.ready;
    assign i_req.ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_scan_last  = (r_idx == (r_count - CW'(1)));

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_count   = r_out_count;
        n_out_value   = r_out_value;
        n_out_present = r_out_present;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;
        w_cmd.op      = CMD_HOLD;
        w_cmd.operand = i_req.operand_value;
        w_cmd.found   = |w_match;

        if (r_state == ST_IDLE) begin
            if (w_accept) begin
                n_out_valid   = 1'b1;
                n_out_value   = '0;
                n_out_present = 1'b0;
                n_out_last    = 1'b1;
                n_out_status  = STATUS_OK;
                unique case (i_req.kind)
                    KIND_INSERT: begin
                        if (r_count < CW'(CAPACITY)) begin
                            w_cmd.op = CMD_INSERT;
                            n_count  = r_count + CW'(1);
                        end else begin
                            n_out_status = STATUS_FULL;
                        end
                    end
                    KIND_DELETE: begin
                        if (|w_match) begin
                            w_cmd.op = CMD_DELETE;
                            n_count  = r_count - CW'(1);
                        end else begin
                            n_out_status = STATUS_NO_MATCH;
                        end
                    end
                    KIND_REPORT: begin
                        if (r_count != '0) begin
                            // results come from the scan
                            n_out_valid = 1'b0;
                            n_state     = ST_SCAN;
                            n_idx       = '0;
                        end
                    end
                    default: begin
                        n_out_status = STATUS_OK;
                    end
                endcase
                n_out_count = ENTRY_W'(n_count);
            end
        end else begin
            if (w_slot_free) begin
                w_cmd.op = CMD_ROTATE;
                n_idx    = r_idx + CW'(1);
                // emit at the end of each run of equal values
                if (w_scan_last || (w_val[0] != w_val[1])) begin
                    n_out_valid   = 1'b1;
                    n_out_count   = ENTRY_W'(r_count);
                    n_out_value   = w_val[0];
                    n_out_present = 1'b1;
                    n_out_last    = w_scan_last;
                    n_out_status  = STATUS_OK;
                end
                if (w_scan_last) begin
                    n_state = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_count   <= n_out_count;
        r_out_value   <= n_out_value;
        r_out_present <= n_out_present;
        r_out_last    <= n_out_last;
        r_out_status  <= n_out_status;
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.entry_count    = r_out_count;
    assign o_res.reported_value = r_out_value;
    assign o_res.value_present  = r_out_present;
    assign o_res.last_of_run    = r_out_last;
    assign o_res.status         = r_out_status;

endmodule

// ===== rtl/smsl_cell.sv =====
// ----------------------------------------------------------------------------
// smsl_cell
// One slot of the sorted chain: holds a value, shifts right on insert,
// left on delete, and rotates toward the head during a report scan.
// ----------------------------------------------------------------------------
module smsl_cell (
    input  logic                 i_clk,
    input  smsl_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_used,
    input  smsl_pkg::t_value     i_left_val,
    input  logic                 i_left_ins,
    input  smsl_pkg::t_value     i_right_val,
    input  logic                 i_right_used,
    input  smsl_pkg::t_value     i_head_val,
    output smsl_pkg::t_value     o_val,
    output logic                 o_ins,
    output logic                 o_match
);
    import smsl_pkg::*;

    t_value r_val;
    t_value n_val;
    logic   w_ge;
    logic   w_gt;

    assign w_ge    = i_used && (r_val >= i_cmd.operand);
    assign w_gt    = i_used && (r_val > i_cmd.operand);
    // insert point is at or left of this cell
    assign o_ins   = w_gt || !i_used;
    assign o_match = i_used && (r_val == i_cmd.operand);
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        unique case (i_cmd.op)
            CMD_HOLD: begin
                n_val = r_val;
            end
            CMD_INSERT: begin
                if (i_left_ins) begin
                    n_val = i_left_val;
                end else if (o_ins) begin
                    n_val = i_cmd.operand;
                end
            end
            CMD_DELETE: begin
                // equal entries are identical, so closing the gap at the first one is enough
                if (i_cmd.found && w_ge) begin
                    n_val = i_right_val;
                end
            end
            CMD_ROTATE: begin
                n_val = i_right_used ? i_right_val : i_head_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
